@@ rtl/core/link_session_and_ack_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Link session and ack controller assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef LINK_SESSION_AND_ACK_CONTROLLER_ASSERT_SVH
`define LINK_SESSION_AND_ACK_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset
`define LSAC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define LSAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LSAC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define LSAC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/core/lsac_pkg.sv @@
// ----------------------------------------------------------------------------
// Link session and ack controller package
// Word types, codes and register defaults shared by the controller.
// ----------------------------------------------------------------------------
package lsac_pkg;

    // Default depth of the reliable message queue
    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    // Action codes
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_PACKET = 2'd1;
    localparam logic [1:0] ACT_QUEUE  = 2'd2;

    // Received packet kinds
    localparam logic [2:0] KIND_VIDEO  = 3'd0;
    localparam logic [2:0] KIND_STATUS = 3'd1;
    localparam logic [2:0] KIND_HELLO  = 3'd2;
    localparam logic [2:0] KIND_TIME   = 3'd3;
    localparam logic [2:0] KIND_LOST   = 3'd4;
    localparam logic [2:0] KIND_FULL   = 3'd5;

    // Session states
    localparam logic [2:0] SES_CONNECTING = 3'd0;
    localparam logic [2:0] SES_QUEUED     = 3'd1;
    localparam logic [2:0] SES_ERROR      = 3'd2;
    localparam logic [2:0] SES_FULL       = 3'd3;
    localparam logic [2:0] SES_LOST       = 3'd4;
    localparam logic [2:0] SES_VERSION    = 3'd5;
    localparam logic [2:0] SES_STREAMING  = 3'd6;

    // Send codes
    localparam logic [1:0] SEND_NONE  = 2'd0;
    localparam logic [1:0] SEND_HELLO = 2'd1;
    localparam logic [1:0] SEND_TIME  = 2'd2;
    localparam logic [1:0] SEND_CTRL  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRANSMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_TMO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVL = 3'd4;

    // Register reset values
    localparam logic [7:0] RST_EXP_VERSION = 8'd0;
    localparam logic [7:0] RST_MAX_RETRIES = 8'd5;
    localparam logic [7:0] RST_RETRANSMIT  = 8'd16;
    localparam logic [7:0] RST_STREAM_TMO  = 8'd125;
    localparam logic [7:0] RST_POLL        = 8'd100;
    localparam logic [7:0] SEQ_MAX         = 8'hFF;

    // Input word
    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         packet_kind;
        logic               packet_complete;
        logic [7:0]         peer_version;
        logic signed [31:0] queue_wait;
        logic [7:0]         ack_seq;
        logic [7:0]         peer_seq;
        logic               has_payload;
        logic [15:0]        message_tag;
    } t_link_in;

    // Result word
    typedef struct packed {
        logic [2:0]         session_state;
        logic [1:0]         send_kind;
        logic               carries_message;
        logic [15:0]        head_tag;
        logic [7:0]         local_seq;
        logic [7:0]         remote_seq;
        logic               deliver_payload;
        logic signed [31:0] wait_time;
        logic               queue_dropped;
    } t_link_out;

endpackage

@@ rtl/core/link_session_and_ack_controller.sv @@
// ----------------------------------------------------------------------------
// Link session and ack controller
// Client side session tracker with stop-and-wait reliable message queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) takes one word per
//   cycle while o_in_stall is low: a refresh tick, a classified received
//   packet or a queue request. Every accepted word yields exactly one
//   result word on the output channel (o_out_valid / i_out_stall /
//   o_out_word), in order, after passing the read stage and then the output
//   register. The session state is updated at the accept edge while the
//   queue memory is read at the head address; the registered read data
//   joins the result in the output stage. Throughput is one word per cycle
//   while the receiver does not stall, as the session registers update on
//   each accepted word and the queue RAM has one write plus one read port.
//   Configuration writes (i_cfg_valid / o_cfg_ready) are always taken and
//   should land only while no word is in flight.
//   Reset clears the session to connecting, empties the queue and loads the
//   register defaults; no clearing pass is needed, queue entries are only
//   used after being written.
//   When the receiver stalls, the result holds in the output register, one
//   more word parks in the read stage, and then o_in_stall rises.
// ----------------------------------------------------------------------------
`include "link_session_and_ack_controller_assert.svh"

module link_session_and_ack_controller #(
    parameter int unsigned QUEUE_DEPTH = lsac_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  lsac_pkg::t_link_in                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output lsac_pkg::t_link_out                o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lsac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                         i_cfg_data
);
    import lsac_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Configuration registers
    logic [7:0] r_exp_version;
    logic [7:0] r_max_retries;
    logic [7:0] r_retransmit;
    logic [7:0] r_stream_tmo;
    logic [7:0] r_poll_interval;

    // Session state
    logic [2:0]         r_session,   n_session;
    logic [7:0]         r_retry,     n_retry;
    logic [7:0]         r_poll,      n_poll;
    logic signed [31:0] r_wait,      n_wait;
    logic [7:0]         r_timer,     n_timer;
    logic [7:0]         r_cseq,      n_cseq;
    logic [7:0]         r_sseq,      n_sseq;
    logic [PTR_W-1:0]   r_head,      n_head;
    logic [PTR_W-1:0]   r_tail,      n_tail;
    logic [CNT_W-1:0]   r_count,     n_count;

    // Queue memory
    logic [15:0] r_mem [QUEUE_DEPTH];
    logic [15:0] r_rd_data;

    // Pipeline
    logic      r_s1_valid;
    t_link_out r_s1_word;
    t_link_out n_s1_word;
    logic      r_out_valid;
    t_link_out r_out_word;
    t_link_out w_out_next;

    logic       w_accept;
    logic       w_out_free;
    logic       w_s1_adv;
    logic       w_push;
    logic [7:0] w_retry_inc;
    logic       w_nonempty;
    logic [1:0] w_send;
    logic       w_carries;
    logic       w_deliver;
    logic       w_dropped;

    // Handshake
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_s1_adv    = r_s1_valid && w_out_free;
    assign o_in_stall  = r_s1_valid && !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    assign w_retry_inc = (r_retry == SEQ_MAX) ? SEQ_MAX : r_retry + 8'd1;
    assign w_nonempty  = (r_count != '0);

    // Compute the session update for the offered word
    always_comb begin
        n_session = r_session;
        n_retry   = r_retry;
        n_poll    = r_poll;
        n_wait    = r_wait;
        n_timer   = r_timer;
        n_cseq    = r_cseq;
        n_sseq    = r_sseq;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        w_send    = SEND_NONE;
        w_carries = 1'b0;
        w_deliver = 1'b0;
        w_dropped = 1'b0;
        w_push    = 1'b0;
        case (i_in_word.action)
            ACT_TICK: begin
                if (r_session == SES_STREAMING) begin
                    w_send = SEND_CTRL;
                    if (r_timer == 8'd0) begin
                        if (w_nonempty) begin
                            w_carries = 1'b1;
                            n_timer   = r_retransmit;
                        end
                    end else begin
                        n_timer = r_timer - 8'd1;
                    end
                    n_retry = w_retry_inc;
                    if (w_retry_inc >= r_stream_tmo) begin
                        n_session = SES_LOST;
                    end
                end else begin
                    if ((r_session == SES_CONNECTING || r_session == SES_QUEUED)
                            && r_poll == 8'd0) begin
                        n_retry = w_retry_inc;
                        if (w_retry_inc >= r_max_retries) begin
                            n_session = SES_ERROR;
                        end else begin
                            w_send = (r_session == SES_CONNECTING) ? SEND_HELLO : SEND_TIME;
                        end
                    end
                    n_poll = (r_poll != 8'd0) ? r_poll - 8'd1 : r_poll_interval;
                end
            end
            ACT_PACKET: begin
                case (i_in_word.packet_kind)
                    KIND_VIDEO: begin
                        n_session = SES_STREAMING;
                        n_retry   = 8'd0;
                    end
                    KIND_STATUS: begin
                        if (i_in_word.packet_complete) begin
                            // Acknowledged head message: pop and advance
                            if (w_nonempty && i_in_word.ack_seq == r_cseq) begin
                                n_head  = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                                n_count = r_count - 1'b1;
                                n_cseq  = r_cseq + 8'd1;
                                n_timer = 8'd0;
                            end
                            // In-order reliable payload from the peer
                            if (i_in_word.peer_seq == r_sseq + 8'd1
                                    && i_in_word.has_payload) begin
                                n_sseq    = r_sseq + 8'd1;
                                w_deliver = 1'b1;
                            end
                        end
                    end
                    KIND_HELLO: begin
                        if (r_session == SES_CONNECTING) begin
                            if (i_in_word.peer_version != r_exp_version) begin
                                n_session = SES_VERSION;
                            end else begin
                                n_session = SES_QUEUED;
                                n_retry   = 8'd0;
                                n_wait    = i_in_word.queue_wait;
                            end
                        end
                    end
                    KIND_TIME: begin
                        if (r_session == SES_QUEUED) begin
                            n_retry = 8'd0;
                            n_wait  = i_in_word.queue_wait;
                        end
                    end
                    KIND_LOST: n_session = SES_LOST;
                    KIND_FULL: n_session = SES_FULL;
                    default: ;
                endcase
            end
            ACT_QUEUE: begin
                if (r_count == CNT_FULL) begin
                    w_dropped = 1'b1;
                end else begin
                    w_push  = 1'b1;
                    n_tail  = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Assemble the result word, head tag joins in the output stage
    always_comb begin
        n_s1_word                 = '0;
        n_s1_word.session_state   = n_session;
        n_s1_word.send_kind       = w_send;
        n_s1_word.carries_message = w_carries;
        n_s1_word.local_seq       = n_cseq;
        n_s1_word.remote_seq      = n_sseq;
        n_s1_word.deliver_payload = w_deliver;
        n_s1_word.wait_time       = n_wait;
        n_s1_word.queue_dropped   = w_dropped;
    end

    // Merge the registered head tag into the outgoing word
    always_comb begin
        w_out_next          = r_s1_word;
        w_out_next.head_tag = r_s1_word.carries_message ? r_rd_data : 16'd0;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version   <= RST_EXP_VERSION;
            r_max_retries   <= RST_MAX_RETRIES;
            r_retransmit    <= RST_RETRANSMIT;
            r_stream_tmo    <= RST_STREAM_TMO;
            r_poll_interval <= RST_POLL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_EXP_VERSION:  r_exp_version   <= i_cfg_data;
                CFG_MAX_RETRIES:  r_max_retries   <= i_cfg_data;
                CFG_RETRANSMIT:   r_retransmit    <= i_cfg_data;
                CFG_STREAM_TMO:   r_stream_tmo    <= i_cfg_data;
                CFG_POLL_INTERVL: r_poll_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Session registers, advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session <= SES_CONNECTING;
            r_retry   <= 8'd0;
            r_poll    <= 8'd0;
            r_wait    <= '0;
            r_timer   <= 8'd0;
            r_cseq    <= 8'd0;
            r_sseq    <= SEQ_MAX;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
        end else if (w_accept) begin
            r_session <= n_session;
            r_retry   <= n_retry;
            r_poll    <= n_poll;
            r_wait    <= n_wait;
            r_timer   <= n_timer;
            r_cseq    <= n_cseq;
            r_sseq    <= n_sseq;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
        end
    end

    // Queue memory: write at tail, read head with the accepted word
    always_ff @(posedge i_clk) begin
        if (w_accept && w_push) begin
            r_mem[r_tail] <= i_in_word.message_tag;
        end
        if (w_accept) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_word <= n_s1_word;
        end
        if (w_s1_adv) begin
            r_out_word <= w_out_next;
        end
    end

    // Checks
    `LSAC_ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL, "queue count over depth")
    `LSAC_ASSERT_CLK(a_empty_ptrs, i_clk, i_rst_n, (r_count == '0) |-> (r_head == r_tail), "empty queue with split pointers")
    `LSAC_ASSERT_CLK(a_carry_ctrl, i_clk, i_rst_n, (o_out_valid && o_out_word.carries_message) |-> (o_out_word.send_kind == SEND_CTRL), "message outside control packet")
    `LSAC_ASSERT_CLK(a_full_stall, i_clk, i_rst_n, (r_s1_valid && r_out_valid && i_out_stall) |-> o_in_stall, "input taken with both stages blocked")
    `LSAC_ASSERT_CLK(a_seq_step, i_clk, i_rst_n, ($past(i_rst_n) && r_cseq != $past(r_cseq)) |-> (r_cseq == $past(r_cseq) + 8'd1), "client sequence skipped")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link session and ack controller testbench
// Drives tick, packet and queue words through the input channel with bursts
// and gaps, stalls the result channel on a run-length pattern, predicts each
// result word from a behavioral copy of the session, sequence and queue
// state, and compares every accepted result field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import lsac_pkg::*;

    localparam int DEPTH      = QUEUE_DEPTH_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_WORDS = 250;

    // Codes with no package constant
    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd6;
    localparam logic [2:0] KIND_RESERVED = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_link_in             i_in_word;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_link_out            o_out_word;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    // Register copy
    logic [7:0] exp_version;
    logic [7:0] retry_limit;
    logic [7:0] resend_ticks;
    logic [7:0] stream_limit;
    logic [7:0] poll_reload;

    // Session, sequence and queue copy
    logic [2:0]         sess;
    logic [7:0]         retry_cnt;
    logic [7:0]         poll_cnt;
    logic signed [31:0] wait_rep;
    logic [7:0]         resend_cnt;
    logic [7:0]         client_sq;
    logic [7:0]         server_sq;
    logic [15:0]        msg_ring [DEPTH];
    int                 ring_rd;
    int                 ring_wr;
    int                 ring_fill;

    t_link_out pending_results [$];

    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit gaps_on = 1'b0;
    int stall_pct = 0;
    int stall_run = 0;
    bit stall_now = 1'b0;

    link_session_and_ack_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Load reset state and register defaults
    function automatic void reset_link_copy();
        exp_version  = RST_EXP_VERSION;
        retry_limit  = RST_MAX_RETRIES;
        resend_ticks = RST_RETRANSMIT;
        stream_limit = RST_STREAM_TMO;
        poll_reload  = RST_POLL;
        sess         = SES_CONNECTING;
        retry_cnt    = 8'd0;
        poll_cnt     = 8'd0;
        wait_rep     = '0;
        resend_cnt   = 8'd0;
        client_sq    = 8'd0;
        server_sq    = SEQ_MAX;
        ring_rd      = 0;
        ring_wr      = 0;
        ring_fill    = 0;
    endfunction

    // Advance the state copy by one input word and return its result word
    function automatic t_link_out predict_link_word(input t_link_in w);
        t_link_out r;
        r = '0;
        case (w.action)
            ACT_TICK: begin
                if (sess == SES_STREAMING) begin
                    r.send_kind = SEND_CTRL;
                    if (resend_cnt == 8'd0) begin
                        if (ring_fill > 0) begin
                            r.carries_message = 1'b1;
                            r.head_tag        = msg_ring[ring_rd];
                            resend_cnt        = resend_ticks;
                        end
                    end else begin
                        resend_cnt = resend_cnt - 8'd1;
                    end
                    if (retry_cnt != 8'hFF) retry_cnt = retry_cnt + 8'd1;
                    if (retry_cnt >= stream_limit) sess = SES_LOST;
                end else begin
                    if ((sess == SES_CONNECTING || sess == SES_QUEUED) && poll_cnt == 8'd0) begin
                        if (retry_cnt != 8'hFF) retry_cnt = retry_cnt + 8'd1;
                        if (retry_cnt >= retry_limit) sess = SES_ERROR;
                        else r.send_kind = (sess == SES_CONNECTING) ? SEND_HELLO : SEND_TIME;
                    end
                    if (poll_cnt != 8'd0) poll_cnt = poll_cnt - 8'd1;
                    else poll_cnt = poll_reload;
                end
            end
            ACT_PACKET: begin
                case (w.packet_kind)
                    KIND_VIDEO: begin
                        sess      = SES_STREAMING;
                        retry_cnt = 8'd0;
                    end
                    KIND_STATUS: begin
                        if (w.packet_complete) begin
                            if (ring_fill > 0 && w.ack_seq == client_sq) begin
                                ring_rd    = (ring_rd + 1) % DEPTH;
                                ring_fill  = ring_fill - 1;
                                client_sq  = client_sq + 8'd1;
                                resend_cnt = 8'd0;
                            end
                            if (w.peer_seq == server_sq + 8'd1 && w.has_payload) begin
                                server_sq         = server_sq + 8'd1;
                                r.deliver_payload = 1'b1;
                            end
                        end
                    end
                    KIND_HELLO: begin
                        if (sess == SES_CONNECTING) begin
                            if (w.peer_version != exp_version) begin
                                sess = SES_VERSION;
                            end else begin
                                sess      = SES_QUEUED;
                                retry_cnt = 8'd0;
                                wait_rep  = w.queue_wait;
                            end
                        end
                    end
                    KIND_TIME: begin
                        if (sess == SES_QUEUED) begin
                            retry_cnt = 8'd0;
                            wait_rep  = w.queue_wait;
                        end
                    end
                    KIND_LOST: sess = SES_LOST;
                    KIND_FULL: sess = SES_FULL;
                    default: ;
                endcase
            end
            ACT_QUEUE: begin
                if (ring_fill >= DEPTH) begin
                    r.queue_dropped = 1'b1;
                end else begin
                    msg_ring[ring_wr] = w.message_tag;
                    ring_wr           = (ring_wr + 1) % DEPTH;
                    ring_fill         = ring_fill + 1;
                end
            end
            default: ;
        endcase
        r.session_state = sess;
        r.local_seq     = client_sq;
        r.remote_seq    = server_sq;
        r.wait_time     = wait_rep;
        return r;
    endfunction

    function automatic string fmt_result(input t_link_out r);
        return $sformatf("ses=%0d send=%0d msg=%b tag=%h lseq=%h rseq=%h dlv=%b wait=%h drop=%b",
                         r.session_state, r.send_kind, r.carries_message, r.head_tag,
                         r.local_seq, r.remote_seq, r.deliver_payload, r.wait_time,
                         r.queue_dropped);
    endfunction

    // Build a word with every field random, then set action and kind
    function automatic t_link_in rand_word(input logic [1:0] act, input logic [2:0] kind);
        t_link_in w;
        w.action          = act;
        w.packet_kind     = kind;
        w.packet_complete = 1'($urandom_range(1));
        w.peer_version    = 8'($urandom);
        w.queue_wait      = $signed($urandom);
        w.ack_seq         = 8'($urandom);
        w.peer_seq        = 8'($urandom);
        w.has_payload     = 1'($urandom_range(1));
        w.message_tag     = 16'($urandom);
        return w;
    endfunction

    // Send one input word, predict its result, then maybe open a gap
    task automatic send_word(input t_link_in w);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_link_word(w));
        if (gaps_on) begin
            if (burst_left == 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_status(input logic [7:0] ack, input logic [7:0] pseq,
                               input logic payload);
        t_link_in w;
        w = rand_word(ACT_PACKET, KIND_STATUS);
        w.packet_complete = 1'b1;
        w.ack_seq         = ack;
        w.peer_seq        = pseq;
        w.has_payload     = payload;
        send_word(w);
    endtask

    task automatic send_tick();
        send_word(rand_word(ACT_TICK, 3'($urandom)));
    endtask

    // Drop valid and wait until every result word has come back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_EXP_VERSION:  exp_version  = val;
            CFG_MAX_RETRIES:  retry_limit  = val;
            CFG_RETRANSMIT:   resend_ticks = val;
            CFG_STREAM_TMO:   stream_limit = val;
            CFG_POLL_INTERVL: poll_reload  = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Connecting and queued: polls, hello, time requests, give-up as error
    task automatic test_session_setup();
        logic [7:0] ver;
        t_link_in   w;
        ver = 8'($urandom_range(1, 254));
        write_reg(CFG_EXP_VERSION, ver);
        write_reg(CFG_MAX_RETRIES, 8'd3);
        write_reg(CFG_RETRANSMIT, 8'd2);
        write_reg(CFG_STREAM_TMO, 8'd6);
        write_reg(CFG_POLL_INTERVL, 8'd1);
        repeat (3) send_tick();
        // short status block is ignored even when it would match
        w = rand_word(ACT_PACKET, KIND_STATUS);
        w.packet_complete = 1'b0;
        w.ack_seq         = client_sq;
        w.peer_seq        = server_sq + 8'd1;
        w.has_payload     = 1'b1;
        send_word(w);
        send_word(rand_word(ACT_PACKET, KIND_TIME));
        send_word(rand_word(ACT_PACKET, KIND_UNKNOWN));
        send_word(rand_word(ACT_PACKET, KIND_RESERVED));
        send_word(rand_word(ACT_UNUSED, 3'($urandom)));
        // hello: version mismatch on some runs, accepted on the rest
        w = rand_word(ACT_PACKET, KIND_HELLO);
        if ($urandom_range(3) == 0) begin
            w.peer_version = ~ver;
        end else begin
            w.peer_version = ver;
            w.queue_wait   = 32'h8000_0000;
        end
        send_word(w);
        repeat (3) send_tick();
        w = rand_word(ACT_PACKET, KIND_TIME);
        w.queue_wait = 32'h7FFF_FFFF;
        send_word(w);
        w = rand_word(ACT_PACKET, KIND_HELLO);
        w.peer_version = ver;
        send_word(w);
        repeat (8) send_tick();
        settle();
    endtask

    // Streaming: control packets, retransmit, ack pop, payload wrap, loss
    task automatic test_streaming_ack();
        t_link_in w;
        w = rand_word(ACT_QUEUE, KIND_VIDEO);
        w.message_tag = 16'hFFFF;
        send_word(w);
        w = rand_word(ACT_QUEUE, KIND_VIDEO);
        w.message_tag = 16'h0000;
        send_word(w);
        send_word(rand_word(ACT_PACKET, KIND_VIDEO));
        repeat (4) send_tick();
        send_status(client_sq, server_sq + 8'd1, 1'b1);
        send_status(client_sq + 8'd1, server_sq, 1'b1);
        send_status(client_sq + 8'd1, server_sq + 8'd1, 1'b0);
        repeat (2) send_tick();
        send_word(rand_word(ACT_PACKET, KIND_LOST));
        send_word(rand_word(ACT_PACKET, KIND_FULL));
        send_word(rand_word(ACT_PACKET, KIND_VIDEO));
        send_status(client_sq, server_sq + 8'd1, 1'b1);
        settle();
    endtask

    // Queue overflow: fill past depth, then pop a couple
    task automatic test_queue_overflow();
        repeat (DEPTH + 1) send_word(rand_word(ACT_QUEUE, 3'($urandom)));
        repeat (2) send_status(client_sq, server_sq + 8'd1, 1'b1);
        settle();
    endtask

    // Zero registers: resend on every tick, immediate loss
    task automatic test_zero_registers();
        write_reg(CFG_MAX_RETRIES, 8'd0);
        write_reg(CFG_POLL_INTERVL, 8'd0);
        write_reg(CFG_RETRANSMIT, 8'd0);
        write_reg(CFG_STREAM_TMO, 8'd255);
        send_word(rand_word(ACT_PACKET, KIND_VIDEO));
        repeat (3) send_tick();
        settle();
        write_reg(CFG_STREAM_TMO, 8'd0);
        send_tick();
        send_word(rand_word(ACT_PACKET, KIND_VIDEO));
        send_tick();
        settle();
    endtask

    // One random word, mostly well-formed streaming traffic
    task automatic random_link_item(input int queue_weight);
        int       r;
        t_link_in w;
        r = $urandom_range(99);
        if (r < 35) begin
            w = rand_word(ACT_TICK, 3'($urandom));
        end else if (r < 35 + queue_weight) begin
            w = rand_word(ACT_QUEUE, 3'($urandom));
        end else if (r < 88) begin
            w = rand_word(ACT_PACKET, KIND_STATUS);
            if ($urandom_range(9) < 8) begin
                w.packet_complete = 1'b1;
                if ($urandom_range(3) != 0) w.ack_seq = client_sq;
                if ($urandom_range(3) != 0) w.peer_seq = server_sq + 8'd1;
            end
        end else if (r < 93) begin
            w = rand_word(ACT_PACKET, KIND_VIDEO);
        end else if (r < 98) begin
            w = rand_word(ACT_PACKET, 3'($urandom_range(2, 7)));
        end else begin
            w = rand_word(ACT_UNUSED, 3'($urandom));
        end
        send_word(w);
    endtask

    // Random phases over several register settings and idle patterns
    task automatic test_random_traffic();
        int phase;
        int k;
        for (phase = 0; phase < 7; phase++) begin
            if (phase == 0) begin
                write_reg(CFG_EXP_VERSION, 8'd0);
                write_reg(CFG_MAX_RETRIES, 8'd1);
                write_reg(CFG_RETRANSMIT, 8'd1);
                write_reg(CFG_STREAM_TMO, 8'd1);
                write_reg(CFG_POLL_INTERVL, 8'd1);
            end else if (phase == 1) begin
                write_reg(CFG_EXP_VERSION, 8'd255);
                write_reg(CFG_MAX_RETRIES, 8'd255);
                write_reg(CFG_RETRANSMIT, 8'd255);
                write_reg(CFG_STREAM_TMO, 8'd255);
                write_reg(CFG_POLL_INTERVL, 8'd255);
            end else begin
                write_reg(CFG_EXP_VERSION, 8'($urandom));
                write_reg(CFG_MAX_RETRIES, 8'($urandom_range(1, 255)));
                write_reg(CFG_RETRANSMIT, 8'($urandom_range(1, 20)));
                write_reg(CFG_STREAM_TMO, 8'($urandom_range(1, 40)));
                write_reg(CFG_POLL_INTERVL, 8'($urandom_range(1, 255)));
            end
            // first phase runs with no idling on either side
            gaps_on   = (phase != 0) && ($urandom_range(3) != 0);
            stall_pct = (phase == 0) ? 0 : $urandom_range(10, 80);
            for (k = 0; k < PHASE_WORDS; k++) random_link_item((phase % 2) ? 30 : 15);
            settle();
        end
    endtask

    // Receiver stall on a run-length pattern
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_now = ($urandom_range(99) < stall_pct);
            stall_run = $urandom_range(1, 12);
        end else begin
            stall_run--;
        end
        i_out_stall <= stall_now;
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_link_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word: %s", fmt_result(o_out_word));
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.session_state !== want.session_state ||
                    o_out_word.send_kind !== want.send_kind ||
                    o_out_word.carries_message !== want.carries_message ||
                    o_out_word.head_tag !== want.head_tag ||
                    o_out_word.local_seq !== want.local_seq ||
                    o_out_word.remote_seq !== want.remote_seq ||
                    o_out_word.deliver_payload !== want.deliver_payload ||
                    o_out_word.wait_time !== want.wait_time ||
                    o_out_word.queue_dropped !== want.queue_dropped) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch\n  expected %s\n  actual   %s",
                                 fmt_result(want), fmt_result(o_out_word));
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        reset_link_copy();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_session_setup();
        test_streaming_ack();
        test_queue_overflow();
        test_zero_registers();
        test_random_traffic();

        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) errors++;
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/lsac_pkg.sv
rtl/core/link_session_and_ack_controller.sv
bench/tb.sv
